@@ hdl/lfhs_pkg.sv @@
package lfhs_pkg;

    localparam int MAX_CELLS_DEF = 64;

    localparam int PADDR_W = 3;

    localparam logic [6:0] FRAME_LEN_RST = 7'd60;
    localparam logic [6:0] FRAME_LEN_MIN = 7'd3;

    localparam logic REG_FRAME_LEN = 1'b0;
    localparam logic REG_SPARK_SAT = 1'b1;

    localparam logic [9:0] DIV3_RECIP = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    localparam logic [7:0] HEAT_SCALE = 8'd191;
    localparam logic [7:0] BAND_WHITE = 8'h80;
    localparam logic [7:0] BAND_YELLOW = 8'h40;
    localparam logic [7:0] LEVEL_FULL = 8'hFF;

    typedef struct packed {
        logic [7:0] cooldown;
        logic [7:0] spark_heat;
    } t_in_item;

    typedef struct packed {
        logic [5:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] heat_value;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

@@ hdl/lfhs_ram.sv @@
module lfhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/lfhs_tap_cell.sv @@
module lfhs_tap_cell #(
    parameter int WEIGHT_SHIFT = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_value,
    output logic [7:0] o_value,
    output logic [9:0] o_term
);

    logic [7:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= 8'd0;
        end else if (i_load) begin
            r_value <= i_value;
        end
    end

    assign o_value = r_value;
    assign o_term  = 10'(r_value) << WEIGHT_SHIFT;

endmodule

@@ hdl/lfhs_color.sv @@
module lfhs_color
    import lfhs_pkg::*;
(
    input  logic [7:0] i_heat,
    output t_rgb       o_rgb
);

    logic [16:0] w_num;
    logic [16:0] w_sum;
    logic [7:0]  w_t;
    logic [7:0]  w_ramp;

    // t = (heat*191 + 127) / 255, division by 255 done as shift-and-add
    assign w_num  = 17'(i_heat) * 17'(HEAT_SCALE) + 17'd128;
    assign w_sum  = w_num + (w_num >> 8);
    assign w_t    = w_sum[15:8];
    assign w_ramp = {w_t[5:0], 2'b00};

    always_comb begin
        if (w_t > BAND_WHITE) begin
            o_rgb = '{red: LEVEL_FULL, green: LEVEL_FULL, blue: w_ramp};
        end else if (w_t > BAND_YELLOW) begin
            o_rgb = '{red: LEVEL_FULL, green: w_ramp, blue: 8'd0};
        end else begin
            o_rgb = '{red: w_ramp, green: 8'd0, blue: 8'd0};
        end
    end

endmodule

@@ hdl/led_fire_heat_step_core.sv @@
// Channel  | Valid       | Ready        | Payload
// ---------+-------------+--------------+-----------------------
// input    | i_in_valid  | o_in_ready   | i_in_item  (t_in_item)
// output   | o_out_valid | i_out_ready  | o_out_item (t_out_item)
// config   | psel/penable| pready (= 1) | paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled; pipeline stages
// are heat read, heat update and color register. The heat memory read for an
// item is issued as it is accepted and its write-back lands as the item leaves
// stage 1, so back-to-back items never wait on the memory.
// Synchronous active-low reset clears the heat store valid bits, counter and
// the cooled-heat cells. A stall on the output holds each full stage that has no
// free stage ahead; o_in_ready drops when all three stages are full and stalled.
module led_fire_heat_step_core
    import lfhs_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_item,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output t_out_item          o_out_item,
    input  logic               i_out_ready,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int         CW      = $clog2(MAX_CELLS);
    localparam logic [6:0] LEN_MAX = 7'(MAX_CELLS);

    logic [6:0]    r_frame_len;
    logic          r_spark_sat;
    logic          w_cfg_idx;
    logic          w_cfg_wr;

    logic [6:0]    w_len;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [6:0]    w_next7;
    logic          w_last;

    logic          r_valid [MAX_CELLS];

    logic          w_out_free;
    logic          w_s2_free;
    logic          w_s2_go;
    logic          w_s1_free;
    logic          w_s1_go;
    logic          w_acc;

    logic          r_s1_v;
    logic [7:0]    r_s1_cool;
    logic [7:0]    r_s1_spark;
    logic [CW-1:0] r_s1_idx;
    logic          r_s1_last;
    logic          r_s1_hit;

    logic [7:0]    w_rdata;
    logic [7:0]    w_cur;
    logic [7:0]    w_cooled;
    logic [7:0]    w_prev_one;
    logic [7:0]    w_prev_two;
    logic [9:0]    w_term_one;
    logic [9:0]    w_term_two;
    logic [9:0]    w_wsum;
    logic [19:0]   w_prod;
    logic [7:0]    w_diff;
    logic [8:0]    w_hsum;
    logic [7:0]    w_heat;

    logic          r_s2_v;
    logic [7:0]    r_s2_heat;
    logic [CW-1:0] r_s2_idx;
    logic          r_s2_last;
    t_rgb          w_rgb;

    logic          r_o_valid;
    t_out_item     r_o_item;

    // configuration
    assign w_cfg_idx = paddr[PADDR_W-1];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (w_cfg_idx == REG_SPARK_SAT) ? {31'd0, r_spark_sat}
                                                    : {25'd0, r_frame_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RST;
            r_spark_sat <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_FRAME_LEN: r_frame_len <= pwdata[6:0];
                REG_SPARK_SAT: r_spark_sat <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign w_len = (r_frame_len < FRAME_LEN_MIN) ? FRAME_LEN_MIN :
                   (r_frame_len > LEN_MAX) ? LEN_MAX : r_frame_len;

    // handshake
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_s2_go    = r_s2_v && w_out_free;
    assign w_s2_free  = !r_s2_v || w_out_free;
    assign w_s1_go    = r_s1_v && w_s2_free;
    assign w_s1_free  = !r_s1_v || w_s2_free;
    assign o_in_ready = w_s1_free;
    assign w_acc      = i_in_valid && w_s1_free;

    // cell counter
    assign w_next7 = 7'(r_cnt) + 7'd1;
    assign w_last  = (w_next7 >= w_len);
    assign n_cnt   = w_last ? '0 : w_next7[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_acc) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CELLS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (w_s1_go) begin
            r_valid[r_s1_idx] <= 1'b1;
        end
    end

    lfhs_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CELLS)
    ) u_heat_ram (
        .i_clk   (i_clk),
        .i_we    (w_s1_go),
        .i_waddr (r_s1_idx),
        .i_wdata (w_heat),
        .i_re    (w_acc),
        .i_raddr (r_cnt),
        .o_rdata (w_rdata)
    );

    // stage 1: heat update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_v <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_cool  <= i_in_item.cooldown;
            r_s1_spark <= i_in_item.spark_heat;
            r_s1_idx   <= r_cnt;
            r_s1_last  <= w_last;
            r_s1_hit   <= r_valid[r_cnt];
        end
    end

    assign w_cur    = r_s1_hit ? w_rdata : 8'd0;
    assign w_cooled = (r_s1_cool > w_cur) ? 8'd0 : (w_cur - r_s1_cool);

    lfhs_tap_cell #(
        .WEIGHT_SHIFT (0)
    ) u_cell_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_s1_go),
        .i_value (w_cooled),
        .o_value (w_prev_one),
        .o_term  (w_term_one)
    );

    lfhs_tap_cell #(
        .WEIGHT_SHIFT (1)
    ) u_cell_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_s1_go),
        .i_value (w_prev_one),
        .o_value (w_prev_two),
        .o_term  (w_term_two)
    );

    // divide by 3 via reciprocal, exact for sums up to 765
    assign w_wsum = w_term_one + w_term_two;
    assign w_prod = 20'(w_wsum) * 20'(DIV3_RECIP);
    assign w_diff = (r_s1_idx >= CW'(2)) ? w_prod[DIV3_SHIFT+7:DIV3_SHIFT] : w_cooled;
    assign w_hsum = 9'(w_diff) + 9'(r_s1_spark);
    assign w_heat = (w_hsum[8] && r_spark_sat) ? LEVEL_FULL : w_hsum[7:0];

    // stage 2: color
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_v <= w_s1_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_s2_heat <= w_heat;
            r_s2_idx  <= r_s1_idx;
            r_s2_last <= r_s1_last;
        end
    end

    lfhs_color u_color (
        .i_heat (r_s2_heat),
        .o_rgb  (w_rgb)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free) begin
            r_o_valid <= w_s2_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_go) begin
            r_o_item.pixel_index <= 6'(r_s2_idx);
            r_o_item.red         <= w_rgb.red;
            r_o_item.green       <= w_rgb.green;
            r_o_item.blue        <= w_rgb.blue;
            r_o_item.heat_value  <= r_s2_heat;
            r_o_item.frame_end   <= r_s2_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

@@ test/led_fire_heat_step_core_tb.sv @@
module led_fire_heat_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lfhs_pkg::*;

    typedef enum logic [1:0] {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_in_item    stim;
        logic        typed;
        t_out_item   want;
        logic        sel;
        logic [31:0] val;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    t_in_item           i_in_item;
    logic               o_in_ready;
    logic               o_out_valid;
    t_out_item          o_out_item;
    logic               i_out_ready = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state
    logic [7:0] heat_mem [MAX_CELLS_DEF];
    logic [5:0] cell_ptr;
    logic [7:0] cooled_last;
    logic [7:0] cooled_older;
    logic [6:0] cfg_len;
    logic       cfg_sat;

    t_out_item   pixel_due [$];
    t_row        script [$];
    bit          steady = 1'b0;
    int unsigned bad_count = 0;
    int unsigned items_sent = 0;
    int unsigned pixels_seen = 0;
    int unsigned reg_writes = 0;
    logic [6:0]  len_edges [7] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd65, 7'd127};

    led_fire_heat_step_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 16);
    end

    task automatic report_bad(input string msg);
        bad_count++;
        if (bad_count <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    function automatic void model_reset();
        foreach (heat_mem[k]) heat_mem[k] = 8'd0;
        cell_ptr     = 6'd0;
        cooled_last  = 8'd0;
        cooled_older = 8'd0;
        cfg_len      = FRAME_LEN_RST;
        cfg_sat      = 1'b0;
    endfunction

    // one cell: cool, diffuse, add spark, write back, color
    function automatic t_out_item fire_step(input t_in_item it);
        int unsigned span;
        int unsigned cur;
        int unsigned cooled;
        int unsigned h;
        int unsigned t;
        int unsigned ramp;
        t_out_item   r;
        span = cfg_len;
        if (span < FRAME_LEN_MIN) span = FRAME_LEN_MIN;
        if (span > MAX_CELLS_DEF) span = MAX_CELLS_DEF;
        cur    = heat_mem[cell_ptr];
        cooled = (it.cooldown > cur) ? 0 : cur - it.cooldown;
        h      = (cell_ptr >= 2) ? (cooled_last + 2 * cooled_older) / 3 : cooled;
        cooled_older = cooled_last;
        cooled_last  = cooled[7:0];
        h = h + it.spark_heat;
        if (h > 255) h = cfg_sat ? 255 : (h & 255);
        heat_mem[cell_ptr] = h[7:0];
        t    = (h * 191 + 127) / 255;
        ramp = ((t & 32'h3F) << 2) & 255;
        if (t > 32'h80) begin
            r.red = 8'd255; r.green = 8'd255; r.blue = ramp[7:0];
        end else if (t > 32'h40) begin
            r.red = 8'd255; r.green = ramp[7:0]; r.blue = 8'd0;
        end else begin
            r.red = ramp[7:0]; r.green = 8'd0; r.blue = 8'd0;
        end
        r.heat_value  = h[7:0];
        r.pixel_index = cell_ptr;
        r.frame_end   = (cell_ptr + 1 >= span);
        cell_ptr      = r.frame_end ? 6'd0 : cell_ptr + 6'd1;
        return r;
    endfunction

    function automatic t_row stim_row(input logic [7:0] cool, input logic [7:0] spark);
        t_row r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.stim  = {cool, spark};
        return r;
    endfunction

    function automatic t_row known_row(input logic [7:0] cool, input logic [7:0] spark,
                                       input logic [5:0] idx, input logic [7:0] red,
                                       input logic [7:0] green, input logic [7:0] blue,
                                       input logic [7:0] heat, input logic fe);
        t_row r;
        r       = stim_row(cool, spark);
        r.typed = 1'b1;
        r.want  = {idx, red, green, blue, heat, fe};
        return r;
    endfunction

    function automatic t_row reg_row(input logic sel, input logic [31:0] val);
        t_row r;
        r      = '0;
        r.kind = ROW_REG;
        r.sel  = sel;
        r.val  = val;
        return r;
    endfunction

    task automatic push_item(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item calc;
        if (!steady && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        calc = fire_step(it);
        pixel_due.push_back(typed ? want : calc);
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pixel_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write, then read back the masked value
    task automatic cfg_write(input logic sel, input logic [31:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(sel) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == REG_FRAME_LEN) cfg_len = val[6:0];
        else cfg_sat = val[0];
        want    = (sel == REG_FRAME_LEN) ? {25'd0, cfg_len} : {31'd0, cfg_sat};
        reg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            report_bad($sformatf("readback reg %0d: expected %h got %h", sel, want, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pixels_seen++;
            if (pixel_due.size() == 0) begin
                report_bad($sformatf("unexpected pixel idx=%0d heat=%0d",
                                     o_out_item.pixel_index, o_out_item.heat_value));
            end else begin
                want = pixel_due.pop_front();
                if (o_out_item.pixel_index !== want.pixel_index
                    || o_out_item.red !== want.red
                    || o_out_item.green !== want.green
                    || o_out_item.blue !== want.blue
                    || o_out_item.heat_value !== want.heat_value
                    || o_out_item.frame_end !== want.frame_end) begin
                    report_bad($sformatf(
                        "pixel exp %0d:%0d,%0d,%0d/%0d/%0d got %0d:%0d,%0d,%0d/%0d/%0d",
                        want.pixel_index, want.red, want.green, want.blue,
                        want.heat_value, want.frame_end,
                        o_out_item.pixel_index, o_out_item.red, o_out_item.green,
                        o_out_item.blue, o_out_item.heat_value, o_out_item.frame_end));
                end
            end
        end
    end

    initial begin : stimulus
        t_row        row;
        t_in_item    it;
        int unsigned phase;
        int unsigned n;
        logic [6:0]  pick;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // from reset: frame of 60, wrapping spark
        script.push_back(known_row(8'd0, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        script.push_back(known_row(8'd0, 8'd255, 6'd1, 8'd255, 8'd255, 8'd252, 8'd255, 1'b0));
        script.push_back(known_row(8'd255, 8'd255, 6'd2, 8'd255, 8'd255, 8'd252, 8'd255, 1'b0));
        script.push_back(stim_row(8'd0, 8'd200));
        // length below range clamps to 3; counter already past the frame
        script.push_back(reg_row(REG_FRAME_LEN, 32'd0));
        script.push_back(known_row(8'd17, 8'd1, 6'd4, 8'd4, 8'd0, 8'd0, 8'd1, 1'b1));
        script.push_back(known_row(8'd0, 8'd255, 6'd0, 8'd255, 8'd255, 8'd252, 8'd255, 1'b0));
        script.push_back(known_row(8'd0, 8'd255, 6'd1, 8'd255, 8'd255, 8'd248, 8'd254, 1'b0));
        script.push_back(stim_row(8'd0, 8'd255));
        script.push_back(reg_row(REG_SPARK_SAT, 32'd1));
        script.push_back(known_row(8'd0, 8'd255, 6'd0, 8'd255, 8'd255, 8'd252, 8'd255, 1'b0));
        script.push_back(known_row(8'd0, 8'd255, 6'd1, 8'd255, 8'd255, 8'd252, 8'd255, 1'b0));
        script.push_back(stim_row(8'd0, 8'd255));
        script.push_back(known_row(8'd255, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        script.push_back(stim_row(8'd200, 8'd0));
        script.push_back(stim_row(8'd0, 8'd128));
        script.push_back(reg_row(REG_FRAME_LEN, 32'd127));
        script.push_back(stim_row(8'h55, 8'hAA));
        script.push_back(stim_row(8'hAA, 8'h55));
        script.push_back(stim_row(8'd1, 8'd254));
        script.push_back(stim_row(8'd254, 8'd1));
        script.push_back(stim_row(8'h0F, 8'hF0));
        script.push_back(reg_row(REG_FRAME_LEN, 32'd64));
        script.push_back(reg_row(REG_FRAME_LEN, 32'd2));
        script.push_back(reg_row(REG_SPARK_SAT, 32'd0));
        script.push_back(stim_row(8'd0, 8'd100));
        script.push_back(stim_row(8'd0, 8'd100));
        script.push_back(stim_row(8'd0, 8'd100));

        foreach (script[k]) begin
            row = script[k];
            if (row.kind == ROW_REG) begin
                settle();
                cfg_write(row.sel, row.val);
            end else begin
                push_item(row.stim, row.typed, row.want);
            end
        end

        for (phase = 0; phase < 14; phase++) begin
            settle();
            steady = (phase == 5 || phase == 6);
            if ($urandom_range(2) == 0) pick = len_edges[$urandom_range(0, 6)];
            else pick = 7'($urandom_range(3, 64));
            if (phase == 0 || $urandom_range(3) != 0) begin
                cfg_write(REG_FRAME_LEN, {25'($urandom), pick});
            end
            cfg_write(REG_SPARK_SAT, {31'($urandom), 1'($urandom_range(1))});
            n = $urandom_range(60, 90);
            repeat (n) begin
                // mostly flame-like: light cooling, sparks near the base
                if ($urandom_range(99) < 75) begin
                    it.cooldown   = 8'($urandom_range(0, 12));
                    it.spark_heat = (cell_ptr < 7 && $urandom_range(99) < 40)
                                    ? 8'($urandom_range(160, 255)) : 8'd0;
                end else begin
                    it.cooldown   = 8'($urandom_range(0, 255));
                    it.spark_heat = 8'($urandom_range(0, 255));
                end
                push_item(it, 1'b0, '0);
            end
        end

        steady = 1'b0;
        settle();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d cell items and %0d pixels over %0d register writes,",
                 items_sent, pixels_seen, reg_writes);
        $display("with clamped frame lengths, wrap and saturate sparks, and random stalls.");
        if (bad_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", bad_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d pixels outstanding", pixel_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
